// ===== hdl/positional_list_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Positional list engine - assertion macros
// Shared concurrent assertion forms used at the top level.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define PLE_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional list engine package
// Sizes, command and status codes, and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ple_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int MODE_W   = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 5;
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INS_AT    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DEL_AT    = 3'd5;
   localparam logic [MODE_W-1:0] MODE_LENGTH    = 3'd6;
   localparam logic [MODE_W-1:0] MODE_DUMP      = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic capture;
      logic exec;
      logic dump_load;
   } ple_cmd_type;

   typedef struct packed {
      logic dump_run;
      logic dump_last;
   } ple_stat_type;

endpackage

// ===== hdl/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// Positional list engine - controller
// Sequences capture, edit and dump steps and owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_ctrl
   import ple_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  ple_stat_type stat,
   output ple_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      out_free  = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               if (stat.dump_run) begin
                  cmd.dump_load = 1'b1;
                  state_in      = stat.dump_last ? S_IDLE : S_DUMP;
               end else begin
                  cmd.exec = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_DUMP: begin
            if (out_free) begin
               cmd.dump_load = 1'b1;
               if (stat.dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.exec || cmd.dump_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/ple_datapath.sv =====
// ----------------------------------------------------------------------------
// Positional list engine - datapath
// List cells with block shift, entry count, dump pointer and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_datapath
   import ple_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  ple_cmd_type                cmd,
   output ple_stat_type               stat,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_entry_value,
   output logic [ENTRY_W-1:0]         rsp_entry_index,
   output logic [ENTRY_W-1:0]         rsp_entry_count,
   output logic                       rsp_last
);

   logic [MODE_W-1:0]         mode_ff;
   logic [POS_W-1:0]          pos_ff;
   logic signed [VALUE_W-1:0] value_ff;

   logic signed [VALUE_W-1:0] cells_ff [CAPACITY];
   logic signed [VALUE_W-1:0] cells_in [CAPACITY];
   logic signed [VALUE_W-1:0] cell_up  [CAPACITY];
   logic signed [VALUE_W-1:0] cell_dn  [CAPACITY];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;

   logic [STATUS_W-1:0]       status_ff, status_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic [ENTRY_W-1:0]        out_index_ff, out_index_in;
   logic [ENTRY_W-1:0]        out_count_ff, out_count_in;
   logic                      out_last_ff, out_last_in;

   logic [STATUS_W-1:0] edit_status;
   logic [CMP_W-1:0]    slot;
   logic [CMP_W-1:0]    cmp_count;
   logic [CMP_W-1:0]    cmp_pos;
   logic                ins_do;
   logic                del_do;
   logic                is_full;
   logic                is_empty;

   // neighbour taps for the block shift
   for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
      if (g == 0) begin : g_first
         assign cell_up[g] = value_ff;
      end else begin : g_rest
         assign cell_up[g] = cells_ff[g-1];
      end
      if (g == CAPACITY - 1) begin : g_end
         assign cell_dn[g] = cells_ff[g];
      end else begin : g_mid
         assign cell_dn[g] = cells_ff[g+1];
      end
   end

   always_comb begin
      cmp_count   = CMP_W'(count_ff);
      cmp_pos     = CMP_W'(pos_ff);
      is_full     = (count_ff == CNT_W'(CAPACITY));
      is_empty    = (count_ff == '0);
      edit_status = ST_OK;
      slot        = '0;
      ins_do      = 1'b0;
      del_do      = 1'b0;
      case (mode_ff)
         MODE_INS_FRONT: begin
            if (is_full) edit_status = ST_FULL;
            else ins_do = 1'b1;
         end
         MODE_INS_BACK: begin
            slot = cmp_count;
            if (is_full) edit_status = ST_FULL;
            else ins_do = 1'b1;
         end
         MODE_INS_AT: begin
            slot = cmp_pos - CMP_W'(1);
            if (cmp_pos == '0 || cmp_pos > cmp_count + CMP_W'(1)) edit_status = ST_BADPOS;
            else if (is_full) edit_status = ST_FULL;
            else ins_do = 1'b1;
         end
         MODE_DEL_FRONT: begin
            if (is_empty) edit_status = ST_EMPTY;
            else del_do = 1'b1;
         end
         MODE_DEL_BACK: begin
            slot = cmp_count - CMP_W'(1);
            if (is_empty) edit_status = ST_EMPTY;
            else del_do = 1'b1;
         end
         MODE_DEL_AT: begin
            slot = cmp_pos - CMP_W'(1);
            if (cmp_pos == '0 || cmp_pos > cmp_count) edit_status = ST_BADPOS;
            else del_do = 1'b1;
         end
         MODE_LENGTH: begin
            edit_status = ST_OK;
         end
         MODE_DUMP: begin
            if (is_empty) edit_status = ST_EMPTY;
         end
         default: begin
            edit_status = ST_OK;
         end
      endcase

      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (ins_do && CMP_W'(i) >= slot) begin
            cells_in[i] = (CMP_W'(i) == slot) ? value_ff : cell_up[i];
         end
         if (del_do && CMP_W'(i) >= slot) begin
            cells_in[i] = cell_dn[i];
         end
      end

      count_in = count_ff;
      if (cmd.exec && ins_do) count_in = count_ff + CNT_W'(1);
      if (cmd.exec && del_do) count_in = count_ff - CNT_W'(1);

      ptr_in = ptr_ff;
      if (cmd.capture) ptr_in = '0;
      else if (cmd.dump_load) ptr_in = ptr_ff + CNT_W'(1);

      status_in    = status_ff;
      out_value_in = out_value_ff;
      out_index_in = out_index_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;
      if (cmd.exec) begin
         status_in    = edit_status;
         out_value_in = '0;
         out_index_in = '0;
         out_count_in = ENTRY_W'(count_in);
         out_last_in  = 1'b1;
      end else if (cmd.dump_load) begin
         status_in    = ST_OK;
         out_value_in = cells_ff[ptr_ff[IDX_W-1:0]];
         out_index_in = ENTRY_W'(ptr_ff + CNT_W'(1));
         out_count_in = ENTRY_W'(count_ff);
         out_last_in  = stat.dump_last;
      end
   end

   assign stat.dump_run  = (mode_ff == MODE_DUMP) && !is_empty;
   assign stat.dump_last = ((ptr_ff + CNT_W'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      if (cmd.exec) begin
         for (int i = 0; i < CAPACITY; i++) begin
            cells_ff[i] <= cells_in[i];
         end
      end
      status_ff    <= status_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_value = out_value_ff;
   assign rsp_entry_index = out_index_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_last        = out_last_ff;

endmodule

// ===== hdl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// Positional list engine - top level
// Bounded ordered list of signed values with positional insert and delete.
// ----------------------------------------------------------------------------
// An accepted item is captured, then executed once the output register is free; its
// result is registered. A dump returns one entry per cycle while the result side is
// ready, from the single list read port. A new item is taken only once the last is
// executed or fully dumped, while its result may still wait in the output register.
// Reset clears the entry count and control; list cells stay undefined until written.
`timescale 1ns / 1ps
`include "positional_list_engine_defines.svh"

module positional_list_engine
   import ple_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // position[4:0], value[36:5]
   input  logic [MODE_W-1:0]     req_tuser,  // mode[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // entry_value[31:0], entry_index[36:32],
                                             // entry_count[41:37]
   output logic [STATUS_W-1:0]   rsp_tuser,  // status[1:0]
   output logic                  rsp_tlast
);

   ple_cmd_type  cmd;
   ple_stat_type stat;

   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_value;
   logic [ENTRY_W-1:0]        rsp_index;
   logic [ENTRY_W-1:0]        rsp_count;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ple_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_tuser),
      .req_position    (req_tdata[POS_W-1:0]),
      .req_value       (req_tdata[POS_W+VALUE_W-1:POS_W]),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_value),
      .rsp_entry_index (rsp_index),
      .rsp_entry_count (rsp_count),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - VALUE_W - 2 * ENTRY_W)'(0), rsp_count, rsp_index, rsp_value};
   assign rsp_tuser = rsp_status;

   `PLE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "item accepted while previous still in work")
   `PLE_ASSERT_HOLDS(a_full_count, clock, reset, rsp_tvalid && rsp_status == ST_FULL, rsp_count == ENTRY_W'(CAPACITY), "full status with list not full")
   `PLE_ASSERT_HOLDS(a_dump_run, clock, reset, rsp_tvalid && !rsp_tlast, rsp_status == ST_OK && rsp_index != '0, "non-final result is not a dump entry")

endmodule

// ===== tb/tb_positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// Positional list engine - testbench
// Drives list commands with bursty valid and checks every result against a
// local model of the list, while the result side is throttled by changing
// stall patterns. A directed pass covers empty-list and edit corner cases,
// then the list is filled to capacity and drained, then random traffic runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_positional_list_engine;
   import ple_pkg::*;

   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 20;
   localparam int RANDOM_CMDS = 130;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  entry_value;
      logic [ENTRY_W-1:0]  entry_index;
      logic [ENTRY_W-1:0]  entry_count;
      logic                last;
   } list_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // position[4:0], value[36:5]
   logic [MODE_W-1:0]     req_tuser;  // mode[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // entry_value[31:0], entry_index[36:32],
                                      // entry_count[41:37]
   logic [STATUS_W-1:0]   rsp_tuser;  // status[1:0]
   logic                  rsp_tlast;

   // model of the stored list
   logic [VALUE_W-1:0] list_cells [CAPACITY];
   int                 list_len;
   list_rsp_type       pending_rsp [$];

   int mismatches;
   int idle_cycles;
   int burst_left;

   positional_list_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------ model
   function automatic void push_rsp(input logic [STATUS_W-1:0] st,
                                    input logic [VALUE_W-1:0] val,
                                    input int idx, input int cnt,
                                    input logic lst);
      list_rsp_type r;
      r.status      = st;
      r.entry_value = val;
      r.entry_index = idx[ENTRY_W-1:0];
      r.entry_count = cnt[ENTRY_W-1:0];
      r.last        = lst;
      pending_rsp.push_back(r);
   endfunction

   function automatic void insert_slot(input int slot, input logic [VALUE_W-1:0] val);
      for (int i = list_len; i > slot; i--)
         list_cells[i] = list_cells[i-1];
      list_cells[slot] = val;
      list_len++;
   endfunction

   function automatic void remove_slot(input int slot);
      for (int i = slot; i + 1 < list_len; i++)
         list_cells[i] = list_cells[i+1];
      list_len--;
   endfunction

   function automatic void predict_list_cmd(input logic [MODE_W-1:0] mode,
                                            input logic [POS_W-1:0] pos,
                                            input logic [VALUE_W-1:0] val);
      logic [STATUS_W-1:0] st;
      st = ST_OK;
      case (mode)
         MODE_INS_FRONT, MODE_INS_BACK: begin
            if (list_len >= CAPACITY)
               st = ST_FULL;
            else
               insert_slot((mode == MODE_INS_FRONT) ? 0 : list_len, val);
         end
         MODE_INS_AT: begin
            if (pos < 1 || pos > list_len + 1)
               st = ST_BADPOS;
            else if (list_len >= CAPACITY)
               st = ST_FULL;
            else
               insert_slot(pos - 1, val);
         end
         MODE_DEL_FRONT, MODE_DEL_BACK: begin
            if (list_len == 0)
               st = ST_EMPTY;
            else
               remove_slot((mode == MODE_DEL_FRONT) ? 0 : list_len - 1);
         end
         MODE_DEL_AT: begin
            if (pos < 1 || pos > list_len)
               st = ST_BADPOS;
            else
               remove_slot(pos - 1);
         end
         MODE_LENGTH: ;
         default: begin
            if (list_len == 0) begin
               push_rsp(ST_EMPTY, '0, 0, 0, 1'b1);
            end else begin
               for (int i = 0; i < list_len; i++)
                  push_rsp(ST_OK, list_cells[i], i + 1, list_len, (i + 1 == list_len));
            end
            return;
         end
      endcase
      push_rsp(st, '0, 0, list_len, 1'b1);
   endfunction

   // --------------------------------------------------------------- sending
   task automatic send_list_cmd(input logic [MODE_W-1:0] mode,
                                input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] val);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 8);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_DATA_W - VALUE_W - POS_W){1'b0}}, val, pos};
      do @(posedge clock); while (!req_tready);
      predict_list_cmd(mode, pos, val);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------- checking
   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = rsp_tuser;
         got.entry_value = rsp_tdata[31:0];
         got.entry_index = rsp_tdata[36:32];
         got.entry_count = rsp_tdata[41:37];
         got.last        = rsp_tlast;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: st=%0d val=%h idx=%0d cnt=%0d last=%b",
                        got.status, got.entry_value, got.entry_index,
                        got.entry_count, got.last);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d val=%h idx=%0d cnt=%0d last=%b / got st=%0d val=%h idx=%0d cnt=%0d last=%b",
                           want.status, want.entry_value, want.entry_index,
                           want.entry_count, want.last, got.status, got.entry_value,
                           got.entry_index, got.entry_count, got.last);
            end
         end
      end
   end

   // receiver back-pressure: pattern changes at the end of each phase
   always @(negedge clock) begin
      int rx_pattern;
      int phase_cycles;
      int hold_left;
      int beat;
      bit hold_ready;
      if (phase_cycles == 0) begin
         rx_pattern   = $urandom_range(0, 3);
         phase_cycles = 64;
      end
      phase_cycles--;
      beat++;
      case (rx_pattern)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ((beat % 4) == 0);
         default: begin
            if (hold_left == 0) begin
               hold_ready = ~hold_ready;
               hold_left  = hold_ready ? $urandom_range(1, 5) : $urandom_range(1, 20);
            end
            hold_left--;
            rsp_tready <= hold_ready;
         end
      endcase
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ----------------------------------------------------------------- tests
   task automatic test_empty_list;
      send_list_cmd(MODE_DEL_FRONT, 5'd0, pick_value());
      send_list_cmd(MODE_DEL_BACK, 5'd1, pick_value());
      send_list_cmd(MODE_DEL_AT, 5'd1, pick_value());
      send_list_cmd(MODE_DEL_AT, 5'd0, pick_value());
      send_list_cmd(MODE_DUMP, 5'd0, pick_value());
      send_list_cmd(MODE_LENGTH, 5'd31, pick_value());
      send_list_cmd(MODE_INS_AT, 5'd0, 32'h1234_5678);
      send_list_cmd(MODE_INS_AT, 5'd2, 32'h1234_5678);
   endtask

   task automatic test_edit_modes;
      send_list_cmd(MODE_INS_FRONT, 5'd0, 32'h7fff_ffff);
      send_list_cmd(MODE_INS_BACK, 5'd31, 32'h8000_0000);
      send_list_cmd(MODE_INS_AT, 5'd2, 32'hffff_ffff);
      send_list_cmd(MODE_INS_AT, 5'd4, 32'h0000_0000);
      send_list_cmd(MODE_INS_AT, 5'd1, 32'h5555_aaaa);
      send_list_cmd(MODE_DUMP, 5'd0, '0);
      send_list_cmd(MODE_DEL_AT, 5'd2, '0);
      send_list_cmd(MODE_DEL_AT, 5'd31, '0);
      send_list_cmd(MODE_INS_AT, 5'd17, '0);
      send_list_cmd(MODE_DEL_FRONT, 5'd0, '0);
      send_list_cmd(MODE_DEL_BACK, 5'd0, '0);
      send_list_cmd(MODE_LENGTH, 5'd0, '0);
      send_list_cmd(MODE_DUMP, 5'd16, '0);
   endtask

   task automatic test_full_list;
      logic [MODE_W-1:0] mode;
      while (list_len < CAPACITY) begin
         case ($urandom_range(0, 2))
            0:       mode = MODE_INS_FRONT;
            1:       mode = MODE_INS_BACK;
            default: mode = MODE_INS_AT;
         endcase
         send_list_cmd(mode, POS_W'($urandom_range(1, list_len + 1)), pick_value());
      end
      send_list_cmd(MODE_INS_FRONT, 5'd0, pick_value());
      send_list_cmd(MODE_INS_BACK, 5'd0, pick_value());
      send_list_cmd(MODE_INS_AT, POS_W'(CAPACITY + 1), pick_value());
      send_list_cmd(MODE_INS_AT, POS_W'(CAPACITY + 2), pick_value());   // bad position wins
      send_list_cmd(MODE_INS_AT, 5'd1, pick_value());
      send_list_cmd(MODE_LENGTH, 5'd0, '0);
      send_list_cmd(MODE_DUMP, 5'd0, '0);
      send_list_cmd(MODE_DEL_AT, POS_W'(CAPACITY), '0);
      while (list_len > 0) begin
         case ($urandom_range(0, 2))
            0:       mode = MODE_DEL_FRONT;
            1:       mode = MODE_DEL_BACK;
            default: mode = MODE_DEL_AT;
         endcase
         send_list_cmd(mode, POS_W'($urandom_range(1, list_len)), pick_value());
      end
      send_list_cmd(MODE_DUMP, 5'd0, '0);
   endtask

   task automatic test_random_traffic;
      int target_len;
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0] pos;
      target_len = 8;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if ((n % 20) == 0)
            target_len = $urandom_range(0, CAPACITY);
         if ($urandom_range(0, 4) == 0) begin
            // noise: any mode, any position
            mode = MODE_W'($urandom_range(0, 7));
            pos  = POS_W'($urandom_range(0, 31));
         end else if ($urandom_range(0, 9) == 0) begin
            mode = ($urandom_range(0, 1) != 0) ? MODE_DUMP : MODE_LENGTH;
            pos  = POS_W'($urandom);
         end else if (list_len < target_len ||
                      (list_len == target_len && $urandom_range(0, 1) != 0)) begin
            mode = MODE_W'($urandom_range(MODE_INS_FRONT, MODE_INS_AT));
            pos  = POS_W'($urandom_range(1, list_len + 1));
         end else begin
            mode = MODE_W'($urandom_range(MODE_DEL_FRONT, MODE_DEL_AT));
            pos  = (list_len > 0) ? POS_W'($urandom_range(1, list_len)) : 5'd0;
         end
         send_list_cmd(mode, pos, pick_value());
      end
   endtask

   // ------------------------------------------------------------------ main
   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = MODE_LENGTH;
      rsp_tready  = 1'b0;
      list_len    = 0;
      mismatches  = 0;
      idle_cycles = 0;
      burst_left  = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_edit_modes();
      test_full_list();
      test_random_traffic();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_ctrl.sv
hdl/ple_datapath.sv
hdl/positional_list_engine.sv
tb/tb_positional_list_engine.sv
